// File: hw/rtl/sra_pkg.sv
// Shared types, widths and constants for the shelf rectangle allocator.
package sra_pkg;

  localparam int MAX_SHELVES_DEF = 1024;
  localparam int MAX_ATLAS       = 2048;

  localparam int CFG_W = 12;
  localparam logic [CFG_W-1:0] ATLAS_RST = CFG_W'(2048);

  localparam int IN_W  = 16;
  localparam int OUT_W = 11;

  localparam int A_EFF_MAX = (MAX_ATLAS < 4095) ? MAX_ATLAS : 4095;
  localparam int AW        = $clog2(A_EFF_MAX + 1);
  localparam int TOP_W     = $clog2(A_EFF_MAX);
  localparam int NRS_W     = $clog2(A_EFF_MAX + 2);
  localparam int HGT_W     = $clog2(A_EFF_MAX + 2);
  localparam int FREE_W    = AW + 1;
  localparam int MUL_W     = $clog2(10 * A_EFF_MAX + 10);

  localparam int FIT_H_SCALE   = 10;
  localparam int FIT_ROW_SCALE = 7;
  localparam int ROW_PAD       = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic            command;
    logic [IN_W-1:0] req_width;
    logic [IN_W-1:0] req_height;
  } in_beat_t;

  typedef struct packed {
    logic             granted;
    logic [OUT_W-1:0] pos_x;
    logic [OUT_W-1:0] pos_y;
    logic             opened_row;
  } out_beat_t;

  typedef struct packed {
    logic [TOP_W-1:0]         top;
    logic [HGT_W-1:0]         height;
    logic signed [FREE_W-1:0] free;
  } shelf_entry_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic emit_zero;
    logic scan_start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic too_big;
    logic scan_done;
  } dp_stat_t;

endpackage

// File: hw/rtl/sra_ctrl.sv
// Sequencer for the shelf allocator: check, scan, decide.
module sra_ctrl import sra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_strobe,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t state_r;
  logic   strobe_r;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_CHECK: begin
        if (stat.is_clear) begin
          cmd.clear     = 1'b1;
          cmd.emit_zero = 1'b1;
        end else if (stat.too_big) begin
          cmd.emit_zero = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DECIDE: begin
        cmd.commit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (stat.is_clear || stat.too_big) begin
            state_r  <= ST_IDLE;
            strobe_r <= 1'b1;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.scan_done) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state_r  <= ST_IDLE;
          strobe_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_decide_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |=> (strobe_r && !busy))
    else $error("decision did not produce a result");

endmodule

// File: hw/rtl/sra_datapath.sv
// Shelf table memory, row scan and placement arithmetic for the allocator.
module sra_datapath import sra_pkg::*; #(
  parameter int MAX_SHELVES = MAX_SHELVES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  in_beat_t         in_beat,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  output out_beat_t        out_beat
);

  localparam int IW    = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CNT_W = $clog2(MAX_SHELVES + 1);
  localparam int SUM_W = ((NRS_W > AW) ? NRS_W : AW) + 1;

  logic [CFG_W-1:0] atlas_r;
  in_beat_t         req_r;
  logic [CNT_W-1:0] count_r;
  logic [NRS_W-1:0] nrs_r;

  shelf_entry_t     mem_r [MAX_SHELVES];
  logic [CNT_W-1:0] rd_idx_r;
  logic [IW-1:0]    rd_tag_r;
  logic             rd_valid_r;
  shelf_entry_t     rd_data_r;

  logic             found_r;
  shelf_entry_t     best_r;
  logic [IW-1:0]    best_idx_r;
  out_beat_t        out_r;

  logic [AW-1:0]    a_eff;
  logic [AW-1:0]    w_a;
  logic [AW-1:0]    h_a;
  logic             rd_more;
  logic             cand;
  logic             better;
  logic [MUL_W-1:0] h_mul;
  logic [MUL_W-1:0] row_mul;
  logic             bad_fit;
  logic             room;
  logic             can_open;
  logic             open_row;
  logic             grant;
  logic [AW+1:0]    w_pad;
  logic [AW+1:0]    best_free_nxt;
  logic [AW+1:0]    new_free_nxt;
  logic [31:0]      px_wide;
  logic [NRS_W-1:0] nrs_nxt;
  logic             wr_en;
  logic [IW-1:0]    wr_idx;
  shelf_entry_t     wr_data;
  out_beat_t        res_nxt;

  always_comb begin
    if (int'(atlas_r) > MAX_ATLAS) begin
      a_eff = AW'(MAX_ATLAS);
    end else begin
      a_eff = AW'(atlas_r);
    end
  end

  assign w_a = req_r.req_width[AW-1:0];
  assign h_a = req_r.req_height[AW-1:0];

  assign stat.is_clear  = (req_r.command == CMD_CLEAR);
  assign stat.too_big   = (req_r.req_width > IN_W'(a_eff)) ||
                          (req_r.req_height > IN_W'(a_eff));
  assign rd_more        = (rd_idx_r < count_r);
  assign stat.scan_done = !rd_more && !rd_valid_r;

  assign cand   = ($signed(rd_data_r.free) > $signed({1'b0, w_a})) &&
                  (((AW+1)'(h_a) + (AW+1)'(1)) < (AW+1)'(rd_data_r.height));
  assign better = !found_r || (rd_data_r.height < best_r.height);

  always_comb begin
    h_mul    = MUL_W'(h_a) * MUL_W'(FIT_H_SCALE);
    row_mul  = MUL_W'(best_r.height) * MUL_W'(FIT_ROW_SCALE);
    bad_fit  = (h_mul < row_mul);
    room     = (SUM_W'(nrs_r) + SUM_W'(h_a)) < SUM_W'(a_eff);
    can_open = room && (count_r < CNT_W'(MAX_SHELVES));
    open_row = (!found_r || bad_fit) && can_open;
    grant    = found_r || open_row;

    w_pad         = {2'b00, w_a} + (AW+2)'(ROW_PAD);
    best_free_nxt = {best_r.free[FREE_W-1], best_r.free} - w_pad;
    new_free_nxt  = {2'b00, a_eff} - w_pad;
    px_wide       = 32'(a_eff) - 32'($signed(best_r.free));
    nrs_nxt       = nrs_r + NRS_W'(h_a) + NRS_W'(ROW_PAD);

    wr_en = cmd.commit && grant;
    if (open_row) begin
      wr_idx         = count_r[IW-1:0];
      wr_data.top    = TOP_W'(nrs_r);
      wr_data.height = HGT_W'(h_a) + HGT_W'(ROW_PAD);
      wr_data.free   = new_free_nxt[FREE_W-1:0];
    end else begin
      wr_idx         = best_idx_r;
      wr_data.top    = best_r.top;
      wr_data.height = best_r.height;
      wr_data.free   = best_free_nxt[FREE_W-1:0];
    end

    res_nxt = '0;
    if (grant) begin
      res_nxt.granted    = 1'b1;
      res_nxt.opened_row = open_row;
      if (open_row) begin
        res_nxt.pos_x = '0;
        res_nxt.pos_y = OUT_W'(nrs_r);
      end else begin
        res_nxt.pos_x = px_wide[OUT_W-1:0];
        res_nxt.pos_y = OUT_W'(best_r.top);
      end
    end
  end

  // shelf table: one read port for the scan, one write port for the commit
  always_ff @(posedge clk) begin
    if (cmd.scan && rd_more) begin
      rd_data_r <= mem_r[rd_idx_r[IW-1:0]];
    end
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_r    <= ATLAS_RST;
      count_r    <= '0;
      nrs_r      <= '0;
      rd_idx_r   <= '0;
      rd_valid_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        atlas_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        count_r <= '0;
        nrs_r   <= '0;
      end
      if (cmd.scan_start) begin
        rd_idx_r   <= '0;
        rd_valid_r <= 1'b0;
        found_r    <= 1'b0;
      end
      if (cmd.scan) begin
        rd_valid_r <= rd_more;
        if (rd_more) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        if (rd_valid_r && cand && better) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.commit && open_row) begin
        count_r <= count_r + CNT_W'(1);
        nrs_r   <= nrs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_beat;
    end
    if (cmd.scan && rd_more) begin
      rd_tag_r <= rd_idx_r[IW-1:0];
    end
    if (cmd.scan && rd_valid_r && cand && better) begin
      best_r     <= rd_data_r;
      best_idx_r <= rd_tag_r;
    end
    if (cmd.emit_zero) begin
      out_r <= '0;
    end else if (cmd.commit) begin
      out_r <= res_nxt;
    end
  end

  assign out_beat = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SHELVES))
    else $error("shelf count beyond table depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> (CNT_W'(rd_tag_r) < count_r))
    else $error("scan read past the open rows");

  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ((count_r == $past(count_r)) ||
                    (count_r == $past(count_r) + CNT_W'(1))))
    else $error("commit changed shelf count by more than one");

endmodule

// File: hw/rtl/shelf_rect_allocator.sv
// Top level of the shelf rectangle allocator for a square texture atlas.
//
//   channel  ports                      direction  qualifier
//   input    in_beat                    in         start & !busy
//   result   out_beat                   out        out_strobe (one cycle)
//   config   cfg_wdata (atlas_size)     in         cfg_we
//
// A clear, or a request larger than the atlas, returns its result from the check
// state. An allocate request goes through the check, scan and decide states: the
// scan reads one row per cycle through the single read port of the shelf table,
// then the decide state commits the placement and returns the result.
// Synchronous active-low reset empties the atlas and sets atlas_size to 2048.
// The receiver cannot stall; busy stays high until the result strobe.
module shelf_rect_allocator import sra_pkg::*; #(
  parameter int MAX_SHELVES = MAX_SHELVES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_beat_t         in_beat,
  output logic             out_strobe,
  output out_beat_t        out_beat,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .stat       (stat),
    .cmd        (cmd)
  );

  sra_datapath #(
    .MAX_SHELVES (MAX_SHELVES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .stat      (stat),
    .out_beat  (out_beat)
  );

endmodule

// File: sim/shelf_rect_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shelf_rect_allocator: directed table and random phases.
module shelf_rect_allocator_tb import sra_pkg::*; ();

  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic             is_cfg;
    logic [CFG_W-1:0] cfg_val;
    in_beat_t         beat;
    logic             typed;
    out_beat_t        want;
  } plan_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_beat_t         in_beat;
  logic             out_strobe;
  out_beat_t        out_beat;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  logic [CFG_W-1:0] atlas_cfg;
  int               row_top    [MAX_SHELVES_DEF];
  int               row_height [MAX_SHELVES_DEF];
  int               row_free   [MAX_SHELVES_DEF];
  int               row_count;
  int               next_top;
  out_beat_t        placements_due[$];
  plan_row_t        plan[$];
  int               fail_count;
  int               cycle_count;

  shelf_rect_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_strobe(out_strobe),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic out_beat_t place_rect(in_beat_t b);
    out_beat_t res;
    int        w;
    int        h;
    int        a;
    int        pick;
    int        px;
    bit        hit;
    bit        opened;
    res    = '0;
    hit    = 1'b0;
    opened = 1'b0;
    pick   = 0;
    w      = int'(b.req_width);
    h      = int'(b.req_height);
    a      = (int'(atlas_cfg) > MAX_ATLAS) ? MAX_ATLAS : int'(atlas_cfg);
    if (b.command == CMD_CLEAR) begin
      row_count = 0;
      next_top  = 0;
    end else if (w <= a && h <= a) begin
      for (int i = 0; i < row_count; i++) begin
        if (row_free[i] > w && h < row_height[i] - 1 &&
            (!hit || row_height[i] < row_height[pick])) begin
          pick = i;
          hit  = 1'b1;
        end
      end
      if ((!hit || h * FIT_H_SCALE < row_height[pick] * FIT_ROW_SCALE) &&
          next_top + h < a && row_count < MAX_SHELVES_DEF) begin
        pick             = row_count;
        row_top[pick]    = next_top;
        row_height[pick] = h + ROW_PAD;
        row_free[pick]   = a;
        next_top         = next_top + h + ROW_PAD;
        row_count        = row_count + 1;
        hit              = 1'b1;
        opened           = 1'b1;
      end
      if (hit) begin
        px             = a - row_free[pick];
        row_free[pick] = row_free[pick] - (w + ROW_PAD);
        res.granted    = 1'b1;
        res.pos_x      = px[OUT_W-1:0];
        res.pos_y      = row_top[pick][OUT_W-1:0];
        res.opened_row = opened;
      end
    end
    return res;
  endfunction

  function automatic in_beat_t random_request();
    in_beat_t b;
    int       cap;
    int       roll;
    b    = '0;
    cap  = (int'(atlas_cfg) > MAX_ATLAS) ? MAX_ATLAS : int'(atlas_cfg);
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      b.command = CMD_CLEAR;
    end else if (roll < 10) begin
      b.req_width  = IN_W'($urandom);
      b.req_height = IN_W'($urandom);
    end else begin
      if ($urandom_range(0, 3) == 0) b.req_width = IN_W'($urandom_range(0, cap));
      else b.req_width = IN_W'($urandom_range(0, cap / 8));
      case ($urandom_range(0, 3))
        0: b.req_height = IN_W'(4 * $urandom_range(1, 4));
        3: b.req_height = IN_W'($urandom_range(0, cap));
        default: b.req_height = IN_W'($urandom_range(0, (cap < 40) ? cap : 40));
      endcase
    end
    return b;
  endfunction

  task automatic plan_known(input logic cmd, input int w, input int h,
                            input int g, input int x, input int y, input int o);
    plan_row_t r;
    r                 = '0;
    r.beat.command    = cmd;
    r.beat.req_width  = w[IN_W-1:0];
    r.beat.req_height = h[IN_W-1:0];
    r.typed           = 1'b1;
    r.want.granted    = g[0];
    r.want.pos_x      = x[OUT_W-1:0];
    r.want.pos_y      = y[OUT_W-1:0];
    r.want.opened_row = o[0];
    plan.insert(plan.size(), r);
  endtask

  task automatic plan_req(input int w, input int h);
    plan_row_t r;
    r                 = '0;
    r.beat.command    = CMD_ALLOC;
    r.beat.req_width  = w[IN_W-1:0];
    r.beat.req_height = h[IN_W-1:0];
    plan.insert(plan.size(), r);
  endtask

  task automatic plan_cfg(input int v);
    plan_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_val = v[CFG_W-1:0];
    plan.insert(plan.size(), r);
  endtask

  task automatic issue(input in_beat_t b, input bit typed, input out_beat_t known);
    out_beat_t predicted;
    @(negedge clk);
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    predicted = place_rect(b);
    placements_due.insert(placements_due.size(), typed ? known : predicted);
  endtask

  task automatic rest(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_atlas(input logic [CFG_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    atlas_cfg = v;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] atlas, input int items, input int idle_pct);
    in_beat_t b;
    write_atlas(atlas);
    repeat (items) begin
      if ($urandom_range(0, 99) < idle_pct) rest($urandom_range(1, 5));
      b = random_request();
      issue(b, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("shelf_rect_allocator_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_strobe) begin
      if (placements_due.size() == 0) begin
        $error("result beat with no request pending");
        fail_count++;
      end else begin
        want = placements_due.pop_front();
        if (out_beat.granted !== want.granted) begin
          $error("granted: expected %0d, actual %0d", want.granted, out_beat.granted);
          fail_count++;
        end
        if (out_beat.pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, actual %0d", want.pos_x, out_beat.pos_x);
          fail_count++;
        end
        if (out_beat.pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, actual %0d", want.pos_y, out_beat.pos_y);
          fail_count++;
        end
        if (out_beat.opened_row !== want.opened_row) begin
          $error("opened_row: expected %0d, actual %0d", want.opened_row, out_beat.opened_row);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t step;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_beat     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    atlas_cfg   = ATLAS_RST;
    row_count   = 0;
    next_top    = 0;
    fail_count  = 0;
    cycle_count = 0;

    plan_known(CMD_ALLOC, 10, 20, 1, 0, 0, 1);
    plan_known(CMD_ALLOC, 10, 18, 1, 12, 0, 0);
    plan_known(CMD_ALLOC, 2049, 0, 0, 0, 0, 0);
    plan_known(CMD_ALLOC, 0, 2049, 0, 0, 0, 0);
    plan_known(CMD_ALLOC, 65535, 65535, 0, 0, 0, 0);
    plan_known(CMD_ALLOC, 2048, 2048, 0, 0, 0, 0);
    plan_known(CMD_ALLOC, 0, 0, 1, 0, 22, 1);
    plan_known(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    plan_known(CMD_ALLOC, 2046, 2045, 1, 0, 0, 1);
    plan_known(CMD_ALLOC, 0, 0, 1, 0, 2047, 1);
    plan_known(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    plan_known(CMD_ALLOC, 2045, 10, 1, 0, 0, 1);
    plan_known(CMD_ALLOC, 0, 9, 1, 2047, 0, 0);
    plan_req(0, 9);
    plan_known(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    plan_req(1000, 8);
    plan_req(1500, 8);
    plan_req(10, 8);
    plan_req(5, 3);
    plan_cfg(0);
    plan_req(0, 0);
    plan_known(CMD_ALLOC, 1, 0, 0, 0, 0, 0);
    plan_known(CMD_ALLOC, 0, 1, 0, 0, 0, 0);
    plan_cfg(4095);
    plan_known(CMD_ALLOC, 2049, 5, 0, 0, 0, 0);
    plan_req(2048, 5);
    plan_cfg(1);
    plan_known(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    plan_known(CMD_ALLOC, 0, 0, 1, 0, 0, 1);
    plan_known(CMD_ALLOC, 1, 0, 0, 0, 0, 0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      step = plan[i];
      if (step.is_cfg) begin
        write_atlas(step.cfg_val);
      end else begin
        if ($urandom_range(0, 3) == 0) rest($urandom_range(1, 5));
        issue(step.beat, step.typed, step.want);
      end
    end

    run_phase(ATLAS_RST, 150, 30);
    run_phase({CFG_W{1'b1}}, 60, 20);
    run_phase(CFG_W'($urandom_range(2, 2047)), 80, 40);
    run_phase(CFG_W'(1), 25, 30);
    run_phase('0, 15, 0);
    run_phase(CFG_W'($urandom_range(2048, 4094)), 80, 25);
    run_phase(ATLAS_RST, 90, 0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("shelf_rect_allocator_tb passed");
    else $display("shelf_rect_allocator_tb failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sra_pkg.sv
hw/rtl/sra_ctrl.sv
hw/rtl/sra_datapath.sv
hw/rtl/shelf_rect_allocator.sv
sim/shelf_rect_allocator_tb.sv
